>>> design/gf2det_pkg.sv
// Shared types and constants for the GF(2) determinant core.
package gf2det_pkg;

  localparam int unsigned ROW_W     = 64;
  localparam int unsigned MAX_N_DEF = 64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_APPLY
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // store the presented row
    logic search;  // pick pivot for the current column
    logic apply;   // eliminate with the picked pivot, advance column
    logic finish;  // emit result, clear matrix state
    logic det;     // determinant value emitted on finish
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic found;     // registered: pivot exists for the current column
    logic last_col;  // current column is the last one (n-1)
  } dp_stat_t;

endpackage

>>> design/gf2det_ctrl.sv
// Sequencer for row loading and column-by-column elimination.
module gf2det_ctrl import gf2det_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     in_last_row,
  input  dp_stat_t stat,
  output logic     busy,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_last_row) begin
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        state_nxt  = ST_APPLY;
      end
      ST_APPLY: begin
        if (!stat.found) begin
          // column without pivot: singular
          cmd.finish = 1'b1;
          cmd.det    = 1'b0;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.apply = 1'b1;
          if (stat.last_col) begin
            cmd.finish = 1'b1;
            cmd.det    = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            state_nxt = ST_SEARCH;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/gf2det_dpath.sv
// Row registers, pivot select and parallel XOR elimination.
module gf2det_dpath import gf2det_pkg::*; #(
  parameter int unsigned MAX_N = MAX_N_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          cmd,
  input  logic [ROW_W-1:0] in_row_bits,
  output dp_stat_t         stat,
  output logic             out_valid,
  output logic             out_determinant,
  output logic             out_row_overflow
);

  localparam int unsigned IDX_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_N + 1);

  // rows shift right one place per finished column, so bit 0 is always
  // the column under elimination
  logic [ROW_W-1:0] rows_r   [MAX_N];
  logic [ROW_W-1:0] rows_nxt [MAX_N];
  logic [MAX_N-1:0] active_r, active_nxt;  // loaded and not yet used as pivot
  logic [MAX_N-1:0] piv_r, piv_nxt;        // one-hot pivot row
  logic             found_r, found_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] col_r, col_nxt;
  logic             ovf_r, ovf_nxt;
  logic             ov_r, ov_nxt;
  logic             od_r, od_nxt;
  logic             oo_r, oo_nxt;

  logic [MAX_N-1:0] cand;
  logic [ROW_W-1:0] piv_row;

  always_comb begin
    for (int unsigned r = 0; r < MAX_N; r++) begin
      cand[r] = active_r[r] & rows_r[r][0];
    end
    piv_row = '0;
    for (int unsigned r = 0; r < MAX_N; r++) begin
      piv_row = piv_row | (rows_r[r] & {ROW_W{piv_r[r]}});
    end
  end

  assign stat.found    = found_r;
  assign stat.last_col = ((col_r + CNT_W'(1)) == cnt_r);

  always_comb begin
    rows_nxt   = rows_r;
    active_nxt = active_r;
    piv_nxt    = piv_r;
    found_nxt  = found_r;
    cnt_nxt    = cnt_r;
    col_nxt    = col_r;
    ovf_nxt    = ovf_r;
    ov_nxt     = 1'b0;
    od_nxt     = od_r;
    oo_nxt     = oo_r;

    if (cmd.load) begin
      if (cnt_r < CNT_W'(MAX_N)) begin
        rows_nxt[cnt_r[IDX_W-1:0]]   = in_row_bits;
        active_nxt[cnt_r[IDX_W-1:0]] = 1'b1;
        cnt_nxt                      = cnt_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    if (cmd.search) begin
      piv_nxt   = cand & (~cand + MAX_N'(1));  // lowest candidate
      found_nxt = |cand;
    end

    if (cmd.apply) begin
      for (int unsigned r = 0; r < MAX_N; r++) begin
        if (cand[r] && !piv_r[r]) begin
          rows_nxt[r] = (rows_r[r] ^ piv_row) >> 1;
        end else begin
          rows_nxt[r] = rows_r[r] >> 1;
        end
      end
      active_nxt = active_r & ~piv_r;
      col_nxt    = col_r + CNT_W'(1);
    end

    if (cmd.finish) begin
      ov_nxt     = 1'b1;
      od_nxt     = cmd.det;
      oo_nxt     = ovf_r;
      active_nxt = '0;
      cnt_nxt    = '0;
      col_nxt    = '0;
      ovf_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      found_r  <= 1'b0;
      cnt_r    <= '0;
      col_r    <= '0;
      ovf_r    <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      active_r <= active_nxt;
      found_r  <= found_nxt;
      cnt_r    <= cnt_nxt;
      col_r    <= col_nxt;
      ovf_r    <= ovf_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rows_r <= rows_nxt;
    piv_r  <= piv_nxt;
    od_r   <= od_nxt;
    oo_r   <= oo_nxt;
  end

  assign out_valid        = ov_r;
  assign out_determinant  = od_r;
  assign out_row_overflow = oo_r;

endmodule

>>> design/gf2_matrix_determinant_core.sv
// Top level of the GF(2) matrix determinant core.
//
// Loads a square matrix over GF(2) one row per item (bit j of in_row_bits is
// column j) and reports its determinant. The item with in_last_row set closes
// the matrix; the number of rows kept sets the order n. Rows beyond MAX_N are
// dropped and out_row_overflow reports it; the determinant then covers the
// first MAX_N rows. An item is taken when start is high and busy is low.
// Rows without in_last_row leave busy low, so the next row can be taken
// at once. The closing row starts elimination column by column: pivot search,
// then XOR of the pivot row into the remaining rows that have the column bit
// set, ending early at the first column without a pivot. The result shows on
// out_determinant / out_row_overflow for exactly one cycle with out_valid
// high, in the cycle in which busy drops; the receiver cannot stall it, so
// capture it then. Column bits at index n and above do not affect the result.
module gf2_matrix_determinant_core import gf2det_pkg::*; #(
  parameter int unsigned MAX_N = MAX_N_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [ROW_W-1:0] in_row_bits,
  input  logic             in_last_row,
  output logic             out_valid,
  output logic             out_determinant,
  output logic             out_row_overflow
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // controller: load / search / apply sequencing
  gf2det_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_last_row (in_last_row),
    .stat        (stat),
    .busy        (busy),
    .cmd         (cmd)
  );

  // datapath: row registers and elimination
  gf2det_dpath #(
    .MAX_N (MAX_N)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_row_bits      (in_row_bits),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_determinant  (out_determinant),
    .out_row_overflow (out_row_overflow)
  );

endmodule
